[sv/tpb_pkg.sv]
package tpb_pkg;

   localparam int DISPLAY_WIDTH_DEF  = 240;
   localparam int DISPLAY_HEIGHT_DEF = 240;

   // Widest pixel address over the whole parameter range (256 x 256)
   localparam int PIX_ADDR_W = 16;

   localparam int CMD_QUEUE_DEPTH = 2;
   localparam int RSP_QUEUE_DEPTH = 4;
   localparam int RSP_CNT_W       = $clog2(RSP_QUEUE_DEPTH + 1);

   localparam logic [2:0] FUNC_SET_CURSOR  = 3'd0;
   localparam logic [2:0] FUNC_SET_POINTER = 3'd1;
   localparam logic [2:0] FUNC_START       = 3'd2;
   localparam logic [2:0] FUNC_PATTERN     = 3'd3;
   localparam logic [2:0] FUNC_READ        = 3'd4;

   localparam logic [1:0] KIND_PIXEL = 2'd0;
   localparam logic [1:0] KIND_FETCH = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;
   localparam logic [1:0] KIND_DONE  = 2'd3;

   localparam int CMD_BG_BIT       = 12;
   localparam int CMD_HOLD_PTR_BIT = 13;
   localparam int CMD_FLIP_BIT     = 14;
   localparam int CMD_TOP_BIT      = 15;

   localparam logic [4:0] ROW_COUNT_FULL = 5'd16;
   localparam logic [7:0] CLEAR_BYTE     = 8'hF0;
   localparam logic [3:0] TRANSPARENT    = 4'hF;

   typedef struct packed {
      logic [2:0]  func;
      logic [15:0] data;
      logic [15:0] pattern;
      logic [7:0]  pixel_x;
      logic [7:0]  pixel_y;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  out_x;
      logic [7:0]  out_y;
      logic [3:0]  colour;
      logic [15:0] fetch_address;
      logic        last;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_CURSOR,
      OP_POINTER,
      OP_START,
      OP_PATTERN,
      OP_READ,
      OP_OTHER
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic [15:0]             data;
      logic [15:0]             pattern;
      logic [7:0]              pixel_x;
      logic [7:0]              pixel_y;
      logic                    in_range;
      logic [PIX_ADDR_W-1:0]   pix_addr;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type item;
   } cmd_slot_type;

   typedef struct packed {
      logic    valid;
      rsp_type item;
   } rsp_push_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PAINT,
      ST_FINISH,
      ST_READ
   } state_type;

   function automatic logic [3:0] shown_colour(input logic [7:0] b);
      return (b[7:4] == TRANSPARENT) ? b[3:0] : b[7:4];
   endfunction

   function automatic rsp_type make_rsp(input logic [1:0] kind, input logic [7:0] x,
                                        input logic [7:0] y, input logic [3:0] col,
                                        input logic [15:0] addr, input logic last);
      rsp_type r;
      r.kind          = kind;
      r.out_x         = x;
      r.out_y         = y;
      r.colour        = col;
      r.fetch_address = addr;
      r.last          = last;
      return r;
   endfunction

endpackage

[sv/tpb_front.sv]
module tpb_front import tpb_pkg::*; #(
   parameter int DISPLAY_WIDTH  = DISPLAY_WIDTH_DEF,
   parameter int DISPLAY_HEIGHT = DISPLAY_HEIGHT_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  req_type      req_item,
   input  logic         clearing,
   output logic         full,
   output cmd_slot_type head,
   input  logic         head_pop
);

   localparam int PTR_W = $clog2(CMD_QUEUE_DEPTH);
   localparam int CNT_W = $clog2(CMD_QUEUE_DEPTH + 1);
   localparam logic [8:0] W9 = 9'(DISPLAY_WIDTH);
   localparam logic [8:0] H9 = 9'(DISPLAY_HEIGHT);
   localparam logic [PIX_ADDR_W-1:0] WIDTH_K = PIX_ADDR_W'(DISPLAY_WIDTH);

   cmd_type          entries_ff [CMD_QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   cmd_type          classified;
   logic             accept;

   // classify the transaction and work out the read address ahead of the engine
   always_comb begin
      classified.data     = req_item.data;
      classified.pattern  = req_item.pattern;
      classified.pixel_x  = req_item.pixel_x;
      classified.pixel_y  = req_item.pixel_y;
      classified.in_range = ({1'b0, req_item.pixel_x} < W9) &&
                            ({1'b0, req_item.pixel_y} < H9);
      classified.pix_addr = PIX_ADDR_W'(req_item.pixel_y) * WIDTH_K +
                            PIX_ADDR_W'(req_item.pixel_x);
      case (req_item.func)
         FUNC_SET_CURSOR:  classified.op = OP_CURSOR;
         FUNC_SET_POINTER: classified.op = OP_POINTER;
         FUNC_START:       classified.op = OP_START;
         FUNC_PATTERN:     classified.op = OP_PATTERN;
         FUNC_READ:        classified.op = OP_READ;
         default:          classified.op = OP_OTHER;
      endcase
   end

   assign full   = (count_ff == CNT_W'(CMD_QUEUE_DEPTH)) || clearing;
   assign accept = push && !full;

   assign head.valid = (count_ff != '0);
   assign head.item  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = accept ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = head_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      case ({accept, head_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entries_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

[sv/tpb_back.sv]
module tpb_back import tpb_pkg::*; #(
   parameter int DISPLAY_WIDTH  = DISPLAY_WIDTH_DEF,
   parameter int DISPLAY_HEIGHT = DISPLAY_HEIGHT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_slot_type         head,
   output logic                 head_pop,
   output logic                 clearing,
   input  logic [RSP_CNT_W-1:0] rsp_count,
   output rsp_push_type         rsp_push
);

   localparam int DEPTH  = DISPLAY_WIDTH * DISPLAY_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
   localparam logic [ADDR_W-1:0] WIDTH_K   = ADDR_W'(DISPLAY_WIDTH);
   localparam logic [8:0] W9 = 9'(DISPLAY_WIDTH);
   localparam logic [8:0] H9 = 9'(DISPLAY_HEIGHT);

   logic [7:0]        pix_store_ff [DEPTH];
   logic [7:0]        rd_data_ff;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [7:0]        cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [15:0]       ptr_ff, ptr_in, cmd_ff, cmd_in;
   logic [4:0]        rows_ff, rows_in;
   logic [15:0]       pat_ff, pat_in;
   logic [3:0]        idx_ff, idx_in;
   logic [ADDR_W-1:0] row_base_ff, row_base_in;
   logic              wb_valid_ff, wb_valid_in;
   logic [7:0]        wb_x_ff, wb_x_in;
   logic [3:0]        wb_col_ff, wb_col_in;
   logic [ADDR_W-1:0] wb_addr_ff, wb_addr_in;
   logic [7:0]        rd_x_ff, rd_x_in, rd_y_ff, rd_y_in;

   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [7:0]        mem_wdata;

   logic              room1, room2;
   logic              pix_bit, pix_on, y_ok;
   logic [7:0]        pix_x;
   logic [3:0]        pix_col;
   logic [7:0]        wb_new;
   logic [15:0]       ptr_next;
   logic [4:0]        rows_next;

   assign room1    = rsp_count < RSP_CNT_W'(RSP_QUEUE_DEPTH);
   assign room2    = rsp_count < RSP_CNT_W'(RSP_QUEUE_DEPTH - 1);
   assign clearing = (state_ff == ST_CLEAR);

   always_comb begin
      pix_bit   = cmd_ff[CMD_FLIP_BIT] ? pat_ff[idx_ff] : pat_ff[~idx_ff];
      pix_x     = cur_x_ff + {4'd0, idx_ff};
      pix_col   = pix_bit ? cmd_ff[3:0] : cmd_ff[7:4];
      y_ok      = {1'b0, cur_y_ff} < H9;
      pix_on    = (cmd_ff[CMD_BG_BIT] || pix_bit) && ({1'b0, pix_x} < W9) && y_ok;
      wb_new    = cmd_ff[CMD_TOP_BIT] ? {wb_col_ff, rd_data_ff[3:0]}
                                      : {rd_data_ff[7:4], wb_col_ff};
      ptr_next  = cmd_ff[CMD_HOLD_PTR_BIT] ? ptr_ff : ptr_ff + 16'd1;
      rows_next = rows_ff - 5'd1;
   end

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      cur_x_in    = cur_x_ff;
      cur_y_in    = cur_y_ff;
      ptr_in      = ptr_ff;
      cmd_in      = cmd_ff;
      rows_in     = rows_ff;
      pat_in      = pat_ff;
      idx_in      = idx_ff;
      row_base_in = row_base_ff;
      wb_valid_in = 1'b0;
      wb_x_in     = wb_x_ff;
      wb_col_in   = wb_col_ff;
      wb_addr_in  = wb_addr_ff;
      rd_x_in     = rd_x_ff;
      rd_y_in     = rd_y_ff;
      mem_we      = 1'b0;
      mem_waddr   = wb_addr_ff;
      mem_wdata   = wb_new;
      mem_re      = 1'b0;
      mem_raddr   = row_base_ff + ADDR_W'(pix_x);
      head_pop    = 1'b0;
      rsp_push    = '0;

      // write-back: finish the read-modify-write, report a changed shown colour
      if (wb_valid_ff) begin
         mem_we = 1'b1;
         if (shown_colour(rd_data_ff) != shown_colour(wb_new)) begin
            rsp_push.valid = 1'b1;
            rsp_push.item  = make_rsp(KIND_PIXEL, wb_x_ff, cur_y_ff,
                                      shown_colour(wb_new), 16'd0, 1'b0);
         end
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = CLEAR_BYTE;
            clr_in    = clr_ff + ADDR_W'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (head.valid && room1) begin
               head_pop = 1'b1;
               case (head.item.op)
                  OP_CURSOR: begin
                     cur_x_in       = head.item.data[7:0];
                     cur_y_in       = head.item.data[15:8];
                     rsp_push.valid = 1'b1;
                     rsp_push.item  = make_rsp(KIND_DONE, 8'd0, 8'd0, 4'd0, 16'd0, 1'b1);
                  end
                  OP_POINTER: begin
                     ptr_in         = head.item.data;
                     rsp_push.valid = 1'b1;
                     rsp_push.item  = make_rsp(KIND_DONE, 8'd0, 8'd0, 4'd0, 16'd0, 1'b1);
                  end
                  OP_START: begin
                     cmd_in         = head.item.data;
                     rows_in        = (head.item.data[11:8] == 4'd0) ? ROW_COUNT_FULL
                                                                     : {1'b0, head.item.data[11:8]};
                     rsp_push.valid = 1'b1;
                     rsp_push.item  = make_rsp(KIND_FETCH, 8'd0, 8'd0, 4'd0, ptr_ff, 1'b1);
                  end
                  OP_PATTERN: begin
                     if (rows_ff == 5'd0) begin
                        rsp_push.valid = 1'b1;
                        rsp_push.item  = make_rsp(KIND_DONE, 8'd0, 8'd0, 4'd0, 16'd0, 1'b1);
                     end else begin
                        pat_in      = head.item.pattern;
                        idx_in      = 4'd0;
                        row_base_in = ADDR_W'(cur_y_ff) * WIDTH_K;
                        state_in    = ST_PAINT;
                     end
                  end
                  OP_READ: begin
                     if (head.item.in_range) begin
                        mem_re    = 1'b1;
                        mem_raddr = head.item.pix_addr[ADDR_W-1:0];
                        rd_x_in   = head.item.pixel_x;
                        rd_y_in   = head.item.pixel_y;
                        state_in  = ST_READ;
                     end else begin
                        rsp_push.valid = 1'b1;
                        rsp_push.item  = make_rsp(KIND_READ, head.item.pixel_x,
                                                  head.item.pixel_y, 4'd0, 16'd0, 1'b1);
                     end
                  end
                  default: begin
                     rsp_push.valid = 1'b1;
                     rsp_push.item  = make_rsp(KIND_DONE, 8'd0, 8'd0, 4'd0, 16'd0, 1'b1);
                  end
               endcase
            end
         end
         ST_PAINT: begin
            // one pixel a cycle if room2; keep room for the write-back in flight
            if (room2) begin
               mem_re      = pix_on;
               wb_valid_in = pix_on;
               wb_x_in     = pix_x;
               wb_col_in   = pix_col;
               wb_addr_in  = row_base_ff + ADDR_W'(pix_x);
               idx_in      = idx_ff + 4'd1;
               if (idx_ff == 4'hF) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (!wb_valid_ff && room1) begin
               cur_y_in       = cur_y_ff + 8'd1;
               ptr_in         = ptr_next;
               rows_in        = rows_next;
               rsp_push.valid = 1'b1;
               if (rows_next != 5'd0) begin
                  rsp_push.item = make_rsp(KIND_FETCH, 8'd0, 8'd0, 4'd0, ptr_next, 1'b1);
               end else begin
                  rsp_push.item = make_rsp(KIND_DONE, 8'd0, 8'd0, 4'd0, 16'd0, 1'b1);
               end
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            if (room1) begin
               rsp_push.valid = 1'b1;
               rsp_push.item  = make_rsp(KIND_READ, rd_x_ff, rd_y_ff,
                                         shown_colour(rd_data_ff), 16'd0, 1'b1);
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_ff      <= '0;
         cur_x_ff    <= '0;
         cur_y_ff    <= '0;
         ptr_ff      <= '0;
         cmd_ff      <= '0;
         rows_ff     <= '0;
         idx_ff      <= '0;
         wb_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         cur_x_ff    <= cur_x_in;
         cur_y_ff    <= cur_y_in;
         ptr_ff      <= ptr_in;
         cmd_ff      <= cmd_in;
         rows_ff     <= rows_in;
         idx_ff      <= idx_in;
         wb_valid_ff <= wb_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pat_ff      <= pat_in;
      row_base_ff <= row_base_in;
      wb_x_ff     <= wb_x_in;
      wb_col_ff   <= wb_col_in;
      wb_addr_ff  <= wb_addr_in;
      rd_x_ff     <= rd_x_in;
      rd_y_ff     <= rd_y_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pix_store_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= pix_store_ff[mem_raddr];
      end
   end

endmodule

[sv/tpb_rsp_queue.sv]
module tpb_rsp_queue import tpb_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  rsp_push_type         rsp_push,
   input  logic                 pop,
   output logic                 empty,
   output rsp_type              rsp_item,
   output logic [RSP_CNT_W-1:0] count
);

   localparam int PTR_W = $clog2(RSP_QUEUE_DEPTH);

   rsp_type              entries_ff [RSP_QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic                 take;

   assign empty    = (count_ff == '0);
   assign take     = pop && !empty;
   assign rsp_item = entries_ff[rd_ptr_ff];
   assign count    = count_ff;

   always_comb begin
      wr_ptr_in = rsp_push.valid ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = take ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      case ({rsp_push.valid, take})
         2'b10:   count_in = count_ff + RSP_CNT_W'(1);
         2'b01:   count_in = count_ff - RSP_CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_push.valid) begin
         entries_ff[wr_ptr_ff] <= rsp_push.item;
      end
   end

endmodule

[sv/two_plane_pattern_blitter_core.sv]
// Two-plane pattern blitter over a one-byte-per-pixel store (top nibble over
// bottom nibble, top 15 shows the bottom). Transactions go in through push/full
// and results come out through empty/pop, oldest first; a short command queue
// parts the intake from the engine and a four-deep result queue parts the engine
// from the consumer. After reset the engine sweeps the whole store to 0xF0, one
// byte a cycle, over all DISPLAY_WIDTH * DISPLAY_HEIGHT bytes (57600 at the
// default 240 x 240) and holds full high until the sweep ends. After that, a
// pattern word for a running blit is taken off the command queue and swept
// over its 16 pixels, limited by the single read and single write port of the
// pixel store (one read-modify-write per pixel per cycle); then its row is
// closed with a fetch or done once the last pixel's write-back has landed. A
// pattern word with no blit running is answered with a done result. The sweep
// stalls whenever the result queue is near full.
module two_plane_pattern_blitter_core import tpb_pkg::*; #(
   parameter int DISPLAY_WIDTH  = DISPLAY_WIDTH_DEF,
   parameter int DISPLAY_HEIGHT = DISPLAY_HEIGHT_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_item,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_item
);

   cmd_slot_type         head;
   logic                 head_pop;
   logic                 clearing;
   logic [RSP_CNT_W-1:0] rsp_count;
   rsp_push_type         rsp_push;

   // intake: classify each transaction and hold it until the engine is free
   tpb_front #(
      .DISPLAY_WIDTH  (DISPLAY_WIDTH),
      .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_item (req_item),
      .clearing (clearing),
      .full     (full),
      .head     (head),
      .head_pop (head_pop)
   );

   // engine: registers, pixel store and the per-pixel sweep
   tpb_back #(
      .DISPLAY_WIDTH  (DISPLAY_WIDTH),
      .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .head_pop  (head_pop),
      .clearing  (clearing),
      .rsp_count (rsp_count),
      .rsp_push  (rsp_push)
   );

   // result queue: drain at the consumer's pace
   tpb_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .rsp_push (rsp_push),
      .pop      (pop),
      .empty    (empty),
      .rsp_item (rsp_item),
      .count    (rsp_count)
   );

`ifndef SYNTHESIS
   // the engine must never post into a full result queue
   a_rsp_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_push.valid |-> (rsp_count != RSP_CNT_W'(RSP_QUEUE_DEPTH)))
      else $error("result posted into a full result queue");

   // no transaction may slip in during the clearing sweep
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !(push && !full))
      else $error("transaction accepted during the clearing sweep");

   // a pixel update is never the closing result of a transaction
   a_pixel_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_push.valid && (rsp_push.item.kind == KIND_PIXEL)) |-> !rsp_push.item.last)
      else $error("pixel update marked as last");

   // the engine only drops a queued command that is really there
   a_pop_valid_head: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> head.valid)
      else $error("command queue popped while empty");
`endif

endmodule
